>>> rtl/rga_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rga_pkg - shared definitions for the rational GCD reduce unit
// Operation codes, field width and sizing constants used across the block.
// ----------------------------------------------------------------------------
package rga_pkg;

    localparam int WORD_WIDTH_DEF = 32;  // default internal word width
    localparam int FIELD_W        = 32;  // width of the numerator/denominator ports
    localparam int OP_W           = 2;
    localparam int MUL_CHUNK      = 16;  // multiplier bits consumed per cycle

    typedef enum logic [OP_W-1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } t_op;

endpackage

>>> rtl/rga_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rga_mul - chunked wrapping multiplier
// Forms a*b modulo 2^WORD_WIDTH, one MUL_CHUNK-bit slice of b per cycle.
// ----------------------------------------------------------------------------
module rga_mul #(
    parameter int WORD_WIDTH = rga_pkg::WORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WORD_WIDTH-1:0] i_a,
    input  logic [WORD_WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [WORD_WIDTH-1:0] o_p
);

    localparam int CH  = rga_pkg::MUL_CHUNK;
    localparam int NCH = (WORD_WIDTH + CH - 1) / CH;
    localparam int MPW = NCH * CH;
    localparam int CW  = (NCH > 1) ? $clog2(NCH) : 1;

    logic                     r_busy;
    logic                     r_done;
    logic [CW-1:0]            r_cnt;
    logic [WORD_WIDTH-1:0]    r_mc;
    logic [MPW-1:0]           r_mp;
    logic [WORD_WIDTH-1:0]    r_acc;
    logic [WORD_WIDTH+CH-1:0] w_pp;

    // partial product of the shifted multiplicand and the current slice
    assign w_pp = r_mc * r_mp[CH-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_mc   <= i_a;
                r_mp   <= MPW'(i_b);
                r_acc  <= '0;
                r_cnt  <= CW'(NCH - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= r_acc + w_pp[WORD_WIDTH-1:0];
                r_mc  <= r_mc << CH;
                r_mp  <= r_mp >> CH;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_p    = r_acc;

endmodule

>>> rtl/rga_gcd.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rga_gcd - binary GCD engine
// One shift or subtract-and-shift per cycle on two unsigned magnitudes.
// ----------------------------------------------------------------------------
module rga_gcd #(
    parameter int WORD_WIDTH = rga_pkg::WORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WORD_WIDTH-1:0] i_a,
    input  logic [WORD_WIDTH-1:0] i_b,
    output logic                  o_done,
    output logic [WORD_WIDTH-1:0] o_g
);

    localparam int KW = $clog2(WORD_WIDTH);

    logic                  r_busy;
    logic                  r_done;
    logic [WORD_WIDTH-1:0] r_u;
    logic [WORD_WIDTH-1:0] r_v;
    logic [KW-1:0]         r_k;
    logic [WORD_WIDTH-1:0] r_g;
    logic                  w_ge;
    logic [WORD_WIDTH-1:0] w_diff;

    assign w_ge   = (r_u >= r_v);
    assign w_diff = w_ge ? (r_u - r_v) : (r_v - r_u);

    // b is never zero here, so the loop ends with u == 0 and gcd = v * 2^k
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_u    <= i_a;
                r_v    <= i_b;
                r_k    <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                if (r_u == '0) begin
                    r_g    <= r_v << r_k;
                    r_done <= 1'b1;
                    r_busy <= 1'b0;
                end else if (!r_u[0] && !r_v[0]) begin
                    r_u <= r_u >> 1;
                    r_v <= r_v >> 1;
                    r_k <= r_k + 1'b1;
                end else if (!r_u[0]) begin
                    r_u <= r_u >> 1;
                end else if (!r_v[0]) begin
                    r_v <= r_v >> 1;
                end else if (w_ge) begin
                    r_u <= w_diff >> 1;
                end else begin
                    r_v <= w_diff >> 1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_g    = r_g;

endmodule

>>> rtl/rga_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rga_div - dual-lane restoring divider
// Divides two unsigned magnitudes by a common divisor, one bit per cycle.
// ----------------------------------------------------------------------------
module rga_div #(
    parameter int WORD_WIDTH = rga_pkg::WORD_WIDTH_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [WORD_WIDTH-1:0] i_a,
    input  logic [WORD_WIDTH-1:0] i_b,
    input  logic [WORD_WIDTH-1:0] i_g,
    output logic                  o_done,
    output logic [WORD_WIDTH-1:0] o_qa,
    output logic [WORD_WIDTH-1:0] o_qb
);

    localparam int CW = $clog2(WORD_WIDTH);

    logic                  r_busy;
    logic                  r_done;
    logic [CW-1:0]         r_cnt;
    logic [WORD_WIDTH-1:0] r_g;
    logic [WORD_WIDTH-1:0] r_qa;
    logic [WORD_WIDTH-1:0] r_qb;
    logic [WORD_WIDTH-1:0] r_ra;
    logic [WORD_WIDTH-1:0] r_rb;
    logic [WORD_WIDTH:0]   w_ta;
    logic [WORD_WIDTH:0]   w_tb;
    logic [WORD_WIDTH:0]   w_sa;
    logic [WORD_WIDTH:0]   w_sb;
    logic                  w_fa;
    logic                  w_fb;

    // partial remainders stay below the divisor, so W bits hold them
    assign w_ta = {r_ra, r_qa[WORD_WIDTH-1]};
    assign w_tb = {r_rb, r_qb[WORD_WIDTH-1]};
    assign w_fa = (w_ta >= {1'b0, r_g});
    assign w_fb = (w_tb >= {1'b0, r_g});
    assign w_sa = w_ta - {1'b0, r_g};
    assign w_sb = w_tb - {1'b0, r_g};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_qa   <= i_a;
                r_qb   <= i_b;
                r_ra   <= '0;
                r_rb   <= '0;
                r_g    <= i_g;
                r_cnt  <= CW'(WORD_WIDTH - 1);
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_ra <= w_fa ? w_sa[WORD_WIDTH-1:0] : w_ta[WORD_WIDTH-1:0];
                r_rb <= w_fb ? w_sb[WORD_WIDTH-1:0] : w_tb[WORD_WIDTH-1:0];
                r_qa <= {r_qa[WORD_WIDTH-2:0], w_fa};
                r_qb <= {r_qb[WORD_WIDTH-2:0], w_fb};
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_qa   = r_qa;
    assign o_qb   = r_qb;

endmodule

>>> rtl/rational_arith_gcd_reduce_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rational_arith_gcd_reduce_unit - fraction add/sub/mul/div with reduction
// Cross products at WORD_WIDTH bits, sign fix-up, binary GCD, exact divide.
// ----------------------------------------------------------------------------
// Usage:
//   Raise start with op and the two fractions; the word is taken on the edge
//   where start is high and busy is low. busy then stays high until the
//   result is out; no new word is taken meanwhile.
//   o_res_num/o_res_den/o_status are marked by o_valid, high for a
//   single cycle. There is no back-pressure: the receiver must take it.
//   A zero denominator gives status 1 and 0/0.
// Sequence:
//   products:   3 for add/sub, 2 for mul/div, one after another
//   sign fix:   makes the denominator positive; a zero one ends here
//   binary GCD: one step of the GCD engine per cycle
//   divide:     skipped when the GCD is 1
//   The GCD loop dominates the time from accept to o_valid. The next word
//   may be offered in the cycle o_valid is high.
// Reset: synchronous, active low; the sequencer returns to idle and any word
//   in flight is dropped.
// ----------------------------------------------------------------------------
module rational_arith_gcd_reduce_unit #(
    parameter int WORD_WIDTH = rga_pkg::WORD_WIDTH_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    input  logic [rga_pkg::OP_W-1:0]            i_op,
    input  logic signed [rga_pkg::FIELD_W-1:0]  i_a_num,
    input  logic signed [rga_pkg::FIELD_W-1:0]  i_a_den,
    input  logic signed [rga_pkg::FIELD_W-1:0]  i_b_num,
    input  logic signed [rga_pkg::FIELD_W-1:0]  i_b_den,
    output logic                                busy,
    output logic                                o_valid,
    output logic signed [rga_pkg::FIELD_W-1:0]  o_res_num,
    output logic signed [rga_pkg::FIELD_W-1:0]  o_res_den,
    output logic                                o_status
);

    localparam int W  = WORD_WIDTH;
    localparam int FW = rga_pkg::FIELD_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_SIGN,
        S_GCD,
        S_DIV
    } t_state;

    // which product the multiplier is working on
    typedef enum logic [1:0] {
        P_FIRST,
        P_CROSS,
        P_DEN
    } t_prod;

    t_state              r_state;
    t_prod               r_pidx;
    rga_pkg::t_op        r_op;
    logic signed [W-1:0] r_an;
    logic signed [W-1:0] r_ad;
    logic signed [W-1:0] r_bn;
    logic signed [W-1:0] r_bd;
    logic signed [W-1:0] r_n;
    logic signed [W-1:0] r_d;
    logic                r_mul_go;
    logic                r_gcd_go;
    logic                r_div_go;
    logic                r_valid;
    logic                r_status;
    logic signed [FW-1:0] r_res_num;
    logic signed [FW-1:0] r_res_den;

    logic [W-1:0]        w_mul_a;
    logic [W-1:0]        w_mul_b;
    logic                w_mul_done;
    logic [W-1:0]        w_mul_p;
    logic [W-1:0]        w_mag_n;
    logic [W-1:0]        w_mag_d;
    logic                w_gcd_done;
    logic [W-1:0]        w_g;
    logic                w_div_done;
    logic [W-1:0]        w_qn;
    logic [W-1:0]        w_qd;
    logic signed [W-1:0] w_sn;
    logic signed [W-1:0] w_sd;

    // the most negative word keeps its bits: magnitude 2^(W-1) unsigned
    assign w_mag_n = r_n[W-1] ? (~r_n + 1'b1) : r_n;
    assign w_mag_d = r_d[W-1] ? (~r_d + 1'b1) : r_d;

    // reapply signs to the quotients
    assign w_sn = r_n[W-1] ? -$signed(w_qn) : $signed(w_qn);
    assign w_sd = r_d[W-1] ? -$signed(w_qd) : $signed(w_qd);

    always_comb begin
        case (r_pidx)
            P_FIRST: begin
                w_mul_a = r_an;
                w_mul_b = (r_op == rga_pkg::OP_MUL) ? r_bn : r_bd;
            end
            P_CROSS: begin
                w_mul_a = r_bn;
                w_mul_b = r_ad;
            end
            default: begin
                w_mul_a = r_ad;
                w_mul_b = (r_op == rga_pkg::OP_DIV) ? r_bn : r_bd;
            end
        endcase
    end

    rga_mul #(.WORD_WIDTH(W)) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_mul_go),
        .i_a     (w_mul_a),
        .i_b     (w_mul_b),
        .o_done  (w_mul_done),
        .o_p     (w_mul_p)
    );

    rga_gcd #(.WORD_WIDTH(W)) u_gcd (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_gcd_go),
        .i_a     (w_mag_n),
        .i_b     (w_mag_d),
        .o_done  (w_gcd_done),
        .o_g     (w_g)
    );

    rga_div #(.WORD_WIDTH(W)) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_div_go),
        .i_a     (w_mag_n),
        .i_b     (w_mag_d),
        .i_g     (w_g),
        .o_done  (w_div_done),
        .o_qa    (w_qn),
        .o_qb    (w_qd)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_mul_go <= 1'b0;
            r_gcd_go <= 1'b0;
            r_div_go <= 1'b0;
            r_valid  <= 1'b0;
        end else begin
            r_mul_go <= 1'b0;
            r_gcd_go <= 1'b0;
            r_div_go <= 1'b0;
            r_valid  <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_op     <= rga_pkg::t_op'(i_op);
                        r_an     <= W'(i_a_num);
                        r_ad     <= W'(i_a_den);
                        r_bn     <= W'(i_b_num);
                        r_bd     <= W'(i_b_den);
                        r_pidx   <= P_FIRST;
                        r_mul_go <= 1'b1;
                        r_state  <= S_MUL;
                    end
                end
                S_MUL: begin
                    if (w_mul_done) begin
                        unique case (r_pidx)
                            P_FIRST: begin
                                r_n      <= w_mul_p;
                                r_mul_go <= 1'b1;
                                if (r_op == rga_pkg::OP_ADD || r_op == rga_pkg::OP_SUB) begin
                                    r_pidx <= P_CROSS;
                                end else begin
                                    r_pidx <= P_DEN;
                                end
                            end
                            P_CROSS: begin
                                r_n      <= (r_op == rga_pkg::OP_SUB) ? (r_n - w_mul_p)
                                                                      : (r_n + w_mul_p);
                                r_pidx   <= P_DEN;
                                r_mul_go <= 1'b1;
                            end
                            P_DEN: begin
                                r_d     <= w_mul_p;
                                r_state <= S_SIGN;
                            end
                            default: begin
                                r_state <= S_IDLE;
                            end
                        endcase
                    end
                end
                S_SIGN: begin
                    if (r_d == '0) begin
                        r_res_num <= '0;
                        r_res_den <= '0;
                        r_status  <= 1'b1;
                        r_valid   <= 1'b1;
                        r_state   <= S_IDLE;
                    end else begin
                        if (r_d[W-1]) begin
                            r_n <= -r_n;
                            r_d <= -r_d;
                        end
                        r_gcd_go <= 1'b1;
                        r_state  <= S_GCD;
                    end
                end
                S_GCD: begin
                    if (w_gcd_done) begin
                        if (w_g > W'(1)) begin
                            r_div_go <= 1'b1;
                            r_state  <= S_DIV;
                        end else begin
                            r_res_num <= FW'(r_n);
                            r_res_den <= FW'(r_d);
                            r_status  <= 1'b0;
                            r_valid   <= 1'b1;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res_num <= FW'(w_sn);
                        r_res_den <= FW'(w_sd);
                        r_status  <= 1'b0;
                        r_valid   <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign busy      = (r_state != S_IDLE);
    assign o_valid   = r_valid;
    assign o_res_num = r_res_num;
    assign o_res_den = r_res_den;
    assign o_status  = r_status;

endmodule

>>> rtl/rga_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rga_checker - port-level checks for the rational GCD reduce unit
// Watches the command and result ports; bound to the top level below.
// ----------------------------------------------------------------------------
module rga_checker (
    input logic                               i_clk,
    input logic                               i_rst_n,
    input logic                               start,
    input logic                               busy,
    input logic                               o_valid,
    input logic signed [rga_pkg::FIELD_W-1:0] o_res_num,
    input logic signed [rga_pkg::FIELD_W-1:0] o_res_den,
    input logic                               o_status
);

    // an accepted word always makes the unit busy
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("word accepted but unit not busy");

    // a result only appears as the unit finishes
    a_valid_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $fell(busy))
        else $error("result strobe without end of work");

    a_valid_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_valid)
        else $error("result strobe longer than one cycle");

    // zero denominator is reported as 0/0
    a_zero_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status) |-> ((o_res_num == '0) && (o_res_den == '0)))
        else $error("zero-denominator result not 0/0");

endmodule

bind rational_arith_gcd_reduce_unit rga_checker u_rga_checker (.*);
